// ===== hdl/lru_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared widths, reset values, control struct and width helpers.
// ----------------------------------------------------------------------------
package lru_pkg;

	localparam int FRAMES_DEF    = 8;
	localparam int PAGE_BITS_DEF = 16;
	localparam int PAGE_W        = 16;
	localparam int CFG_W         = 4;
	localparam int IDX_OUT_W     = 3;
	localparam int FCNT_W        = 32;
	localparam int CFG_MAX       = 2**CFG_W - 1;

	localparam logic [CFG_W-1:0] LIMIT_RST = 4'd4;

	typedef struct packed {
		logic upd;
		logic hit;
		logic fill;
	} ctrl_t;

	function automatic int rank_w(input int frames);
		return (frames > 1) ? $clog2(frames) : 1;
	endfunction

	function automatic int cnt_w(input int frames);
		return $clog2(frames + 1);
	endfunction

	function automatic int act_n(input int frames);
		return (frames < CFG_MAX) ? frames : CFG_MAX;
	endfunction

endpackage

// ===== hdl/lru_cell.sv =====
// ----------------------------------------------------------------------------
// LRU frame cell
// One frame: page, valid bit and recency rank, with local compare and update.
// ----------------------------------------------------------------------------
module lru_cell #(
	parameter int FRAMES    = lru_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF,
	parameter int INDEX     = 0,
	localparam int RW = lru_pkg::rank_w(FRAMES),
	localparam int CW = lru_pkg::cnt_w(FRAMES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lru_pkg::ctrl_t       ctrl,
	input  logic [PAGE_BITS-1:0] page,
	input  logic [CW-1:0]        limit,
	input  logic [CW-1:0]        filled,
	input  logic [RW-1:0]        sel_rank,
	input  logic                 victim,
	input  logic                 hit_in,
	output logic                 hit_out,
	output logic                 sel,
	output logic                 elig,
	output logic [RW-1:0]        rank,
	output logic [PAGE_BITS-1:0] stored_page
);

	localparam logic [CW-1:0] ME = CW'(INDEX);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic [RW-1:0]        rank_q;
	logic                 active;
	logic                 match;
	logic                 age;

	assign active      = (ME < limit);
	assign elig        = valid_q & active;
	assign match       = elig & (page_q == page);
	assign hit_out     = hit_in | match;
	assign rank        = rank_q;
	assign stored_page = page_q;
	assign age         = valid_q & (ctrl.fill | (rank_q < sel_rank));

	always_comb begin
		if (ctrl.hit) begin
			sel = match & ~hit_in;
		end else if (ctrl.fill) begin
			sel = (filled == ME);
		end else begin
			sel = victim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (ctrl.upd) begin
			if (sel) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (age) begin
				rank_q <= rank_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.upd && sel && !ctrl.hit) begin
			page_q <= page;
		end
	end

endmodule

// ===== hdl/lru_pick.sv =====
// ----------------------------------------------------------------------------
// LRU victim picker
// Marks the eligible frame that no other eligible frame outranks in age.
// ----------------------------------------------------------------------------
module lru_pick #(
	parameter int FRAMES = lru_pkg::FRAMES_DEF,
	localparam int RW = lru_pkg::rank_w(FRAMES),
	localparam int AN = lru_pkg::act_n(FRAMES)
) (
	input  logic [RW-1:0]     rank [FRAMES],
	input  logic [FRAMES-1:0] elig,
	output logic [FRAMES-1:0] victim
);

	logic [FRAMES-1:0] older;

	always_comb begin
		older  = '0;
		victim = '0;
		for (int i = 0; i < AN; i++) begin
			for (int k = 0; k < AN; k++) begin
				if (k != i && elig[k] && rank[k] > rank[i]) begin
					older[i] = 1'b1;
				end
			end
			victim[i] = elig[i] & ~older[i];
		end
	end

endmodule

// ===== hdl/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement
// Resident page table with LRU replacement and a saturating fault counter.
// ----------------------------------------------------------------------------
// A page reference is captured on acceptance; then the row of frame cells
// compares the page, picks the hit, next empty or least recently used frame,
// and updates ranks and pages while the result register loads. page_stall is
// high from acceptance until that update, so no new reference is taken
// meanwhile; a stalled result holds the update until the result register
// drains. No clearing pass follows reset. frames_in_use is clamped to 1..FRAMES.
module lru_page_replacement #(
	parameter int FRAMES    = lru_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lru_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          page_valid,
	output logic                          page_stall,
	input  logic [lru_pkg::PAGE_W-1:0]    page_number,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          fault,
	output logic [lru_pkg::IDX_OUT_W-1:0] frame_index,
	output logic                          evicted_valid,
	output logic [lru_pkg::PAGE_W-1:0]    evicted_page,
	output logic [lru_pkg::FCNT_W-1:0]    fault_total
);

	localparam int RW = lru_pkg::rank_w(FRAMES);
	localparam int CW = lru_pkg::cnt_w(FRAMES);

	logic [lru_pkg::CFG_W-1:0]     frames_in_use_q;
	logic                          busy_q;
	logic [PAGE_BITS-1:0]          page_s1;
	logic [CW-1:0]                 filled_q;
	logic [lru_pkg::FCNT_W-1:0]    fault_cnt_q;
	logic                          result_valid_q;
	logic                          fault_q;
	logic [lru_pkg::IDX_OUT_W-1:0] frame_index_q;
	logic                          evicted_valid_q;
	logic [lru_pkg::PAGE_W-1:0]    evicted_page_q;

	logic [lru_pkg::CFG_W-1:0] lim_raw;
	logic [CW-1:0]             limit;
	lru_pkg::ctrl_t            ctrl;
	logic                      replace;
	logic [FRAMES:0]           hit_chain;
	logic [FRAMES-1:0]         sel;
	logic [FRAMES-1:0]         elig;
	logic [FRAMES-1:0]         victim;
	logic [RW-1:0]             rank [FRAMES];
	logic [PAGE_BITS-1:0]      cpage [FRAMES];
	logic [RW-1:0]             sel_rank;
	logic [RW-1:0]             sel_idx;
	logic [PAGE_BITS-1:0]      sel_page;

	always_comb begin
		lim_raw = frames_in_use_q;
		if (lim_raw == '0) begin
			lim_raw = lru_pkg::CFG_W'(1);
		end
		if (32'(lim_raw) > FRAMES) begin
			lim_raw = lru_pkg::CFG_W'(FRAMES);
		end
		limit = CW'(lim_raw);
	end

	assign hit_chain[0] = 1'b0;
	assign ctrl.upd     = busy_q & (~result_valid_q | ~result_stall);
	assign ctrl.hit     = hit_chain[FRAMES];
	assign ctrl.fill    = ~hit_chain[FRAMES] & (filled_q < limit);
	assign replace      = ~ctrl.hit & ~ctrl.fill;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		lru_cell #(
			.FRAMES    (FRAMES),
			.PAGE_BITS (PAGE_BITS),
			.INDEX     (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.page        (page_s1),
			.limit       (limit),
			.filled      (filled_q),
			.sel_rank    (sel_rank),
			.victim      (victim[i]),
			.hit_in      (hit_chain[i]),
			.hit_out     (hit_chain[i+1]),
			.sel         (sel[i]),
			.elig        (elig[i]),
			.rank        (rank[i]),
			.stored_page (cpage[i])
		);
	end

	lru_pick #(
		.FRAMES (FRAMES)
	) u_pick (
		.rank   (rank),
		.elig   (elig),
		.victim (victim)
	);

	always_comb begin
		sel_rank = '0;
		sel_idx  = '0;
		sel_page = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (sel[i]) begin
				sel_rank = sel_rank | rank[i];
				sel_idx  = sel_idx | RW'(i);
				sel_page = sel_page | cpage[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= lru_pkg::LIMIT_RST;
			busy_q          <= 1'b0;
			filled_q        <= '0;
			fault_cnt_q     <= '0;
			result_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				frames_in_use_q <= cfg_wdata;
			end
			if (page_valid && !busy_q) begin
				busy_q <= 1'b1;
			end else if (ctrl.upd) begin
				busy_q <= 1'b0;
			end
			if (ctrl.upd) begin
				result_valid_q <= 1'b1;
				if (ctrl.fill) begin
					filled_q <= filled_q + CW'(1);
				end
				if (!ctrl.hit && fault_cnt_q != '1) begin
					fault_cnt_q <= fault_cnt_q + lru_pkg::FCNT_W'(1);
				end
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (page_valid && !busy_q) begin
			page_s1 <= PAGE_BITS'(page_number);
		end
		if (ctrl.upd) begin
			fault_q         <= ~ctrl.hit;
			frame_index_q   <= lru_pkg::IDX_OUT_W'(sel_idx);
			evicted_valid_q <= replace;
			evicted_page_q  <= replace ? lru_pkg::PAGE_W'(sel_page) : '0;
		end
	end

	assign page_stall    = busy_q;
	assign result_valid  = result_valid_q;
	assign fault         = fault_q;
	assign frame_index   = frame_index_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;
	assign fault_total   = fault_cnt_q;

`ifndef SYNTHESIS
	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.upd |-> $onehot(sel))
		else $error("frame select not one-hot during update");

	a_evict_fault: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (!evicted_valid_q || fault_q))
		else $error("eviction reported without a fault");

	a_filled_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(filled_q) <= FRAMES)
		else $error("filled frame count beyond frame count");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.upd && ctrl.hit) |=> $stable(fault_cnt_q))
		else $error("fault count moved on a hit");
`endif

endmodule

// ===== sim/lru_page_replacement_tb.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Drives page references through the valid/stall handshake. Frame-count
// settings change between phases, and the sender and receiver idle at
// several rates. A built-in LRU page table predicts every result, and the
// results are checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_FRAMES  = lru_pkg::FRAMES_DEF;
	localparam int PAGE_W      = lru_pkg::PAGE_W;
	localparam int CFG_W       = lru_pkg::CFG_W;
	localparam int IDX_OUT_W   = lru_pkg::IDX_OUT_W;
	localparam int FCNT_W      = lru_pkg::FCNT_W;
	localparam int SILENT_MAX  = 3000;
	localparam int SETTLE_CYC  = 4;
	localparam int CHUNKS      = 14;
	localparam int CHUNK_ITEMS = 98;

	typedef enum logic [1:0] {
		STIM_PAGE,
		STIM_SET_FRAMES,
		STIM_QUIESCE,
		STIM_PACING
	} stim_kind_t;

	typedef struct {
		stim_kind_t         kind;
		logic [PAGE_W-1:0]  page;
		logic [CFG_W-1:0]   frames;
		int                 idle_pct;
		int                 stall_pct;
	} stim_t;

	typedef struct packed {
		logic                 fault;
		logic [IDX_OUT_W-1:0] frame_index;
		logic                 evicted_valid;
		logic [PAGE_W-1:0]    evicted_page;
		logic [FCNT_W-1:0]    fault_total;
	} page_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 page_valid = 1'b0;
	logic                 page_stall;
	logic [PAGE_W-1:0]    page_number = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic                 fault;
	logic [IDX_OUT_W-1:0] frame_index;
	logic                 evicted_valid;
	logic [PAGE_W-1:0]    evicted_page;
	logic [FCNT_W-1:0]    fault_total;

	stim_t        stimulus[$];
	page_result_t expected_results[$];
	int           sender_idle_pct = 0;
	int           receiver_stall_pct = 0;
	logic         page_taken = 1'b0;
	int           silent_cycles = 0;
	int           mismatches = 0;

	logic [PAGE_W-1:0] table_page[NUM_FRAMES];
	logic              table_valid[NUM_FRAMES];
	int                table_rank[NUM_FRAMES];
	int                table_filled = 0;
	logic [FCNT_W-1:0] table_faults = '0;
	logic [CFG_W-1:0]  frames_limit = lru_pkg::LIMIT_RST;

	lru_page_replacement dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.page_valid    (page_valid),
		.page_stall    (page_stall),
		.page_number   (page_number),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.fault         (fault),
		.frame_index   (frame_index),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_total   (fault_total)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < NUM_FRAMES; i++) begin
			table_page[i] = '0;
			table_valid[i] = 1'b0;
			table_rank[i] = 0;
		end
	end

	function automatic void make_most_recent(input int f);
		for (int i = 0; i < NUM_FRAMES; i++) begin
			if (i != f && table_valid[i] && table_rank[i] < table_rank[f])
				table_rank[i]++;
		end
		table_rank[f] = 0;
	endfunction

	function automatic page_result_t resolve_reference(input logic [PAGE_W-1:0] pg);
		page_result_t r;
		int           lim;
		int           f;
		int           best_rank;
		logic         hit;
		r = '0;
		hit = 1'b0;
		f = 0;
		lim = (frames_limit == 0) ? 1 : ((frames_limit > NUM_FRAMES) ? NUM_FRAMES :
			int'(frames_limit));
		for (int i = 0; i < lim; i++) begin
			if (!hit && table_valid[i] && table_page[i] == pg) begin
				hit = 1'b1;
				f = i;
			end
		end
		if (hit) begin
			make_most_recent(f);
		end else begin
			if (table_faults != '1)
				table_faults++;
			if (table_filled < lim) begin
				f = table_filled;
				table_filled++;
				for (int i = 0; i < NUM_FRAMES; i++) begin
					if (table_valid[i])
						table_rank[i]++;
				end
				table_valid[f] = 1'b1;
				table_page[f] = pg;
				table_rank[f] = 0;
			end else begin
				best_rank = -1;
				for (int i = 0; i < lim; i++) begin
					if (table_valid[i] && table_rank[i] > best_rank) begin
						best_rank = table_rank[i];
						f = i;
					end
				end
				r.evicted_valid = 1'b1;
				r.evicted_page = table_page[f];
				table_page[f] = pg;
				make_most_recent(f);
			end
		end
		r.fault = !hit;
		r.frame_index = f[IDX_OUT_W-1:0];
		r.fault_total = table_faults;
		return r;
	endfunction

	function automatic void add_page(input logic [PAGE_W-1:0] pg);
		stim_t s;
		s = '{STIM_PAGE, pg, '0, 0, 0};
		stimulus.push_back(s);
	endfunction

	function automatic void add_frames(input logic [CFG_W-1:0] n);
		stim_t s;
		s = '{STIM_SET_FRAMES, '0, n, 0, 0};
		stimulus.push_back(s);
	endfunction

	function automatic void add_pacing(input int idle_pct, input int stall_pct);
		stim_t s;
		s = '{STIM_PACING, '0, '0, idle_pct, stall_pct};
		stimulus.push_back(s);
	endfunction

	function automatic void add_quiesce();
		stim_t s;
		s = '{STIM_QUIESCE, '0, '0, 0, 0};
		stimulus.push_back(s);
	endfunction

	always @(negedge clk) begin : drive
		stim_t head;
		logic  next_valid;
		logic  next_we;
		logic  idle_now;
		next_valid = page_valid;
		next_we = 1'b0;
		idle_now = !page_valid && expected_results.size() == 0 &&
			silent_cycles >= SETTLE_CYC;
		if (arst_n) begin
			if (!page_valid || page_taken) begin
				next_valid = 1'b0;
				if (stimulus.size() != 0) begin
					head = stimulus[0];
					case (head.kind)
						STIM_PACING: begin
							sender_idle_pct = head.idle_pct;
							receiver_stall_pct = head.stall_pct;
							void'(stimulus.pop_front());
						end
						STIM_PAGE: begin
							if ($urandom_range(99) >= sender_idle_pct) begin
								page_number <= head.page;
								next_valid = 1'b1;
								void'(stimulus.pop_front());
							end
						end
						STIM_SET_FRAMES: begin
							if (idle_now) begin
								cfg_wdata <= head.frames;
								next_we = 1'b1;
								void'(stimulus.pop_front());
							end
						end
						default: begin
							if (idle_now)
								void'(stimulus.pop_front());
						end
					endcase
				end
			end
			result_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
		page_valid <= next_valid;
		cfg_we <= next_we;
	end

	always @(posedge clk) begin : observe
		page_result_t want;
		logic         activity;
		activity = 1'b0;
		if (arst_n) begin
			if (cfg_we) begin
				frames_limit = cfg_wdata;
				activity = 1'b1;
			end
			if (page_valid && !page_stall) begin
				expected_results.push_back(resolve_reference(page_number));
				activity = 1'b1;
			end
			if (result_valid && !result_stall) begin
				activity = 1'b1;
				if (expected_results.size() == 0) begin
					$error("result with no item outstanding");
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (fault !== want.fault) begin
						$error("fault: expected %0d, got %0d", want.fault, fault);
						mismatches++;
					end
					if (frame_index !== want.frame_index) begin
						$error("frame_index: expected %0d, got %0d",
							want.frame_index, frame_index);
						mismatches++;
					end
					if (evicted_valid !== want.evicted_valid) begin
						$error("evicted_valid: expected %0d, got %0d",
							want.evicted_valid, evicted_valid);
						mismatches++;
					end
					if (evicted_page !== want.evicted_page) begin
						$error("evicted_page: expected %h, got %h",
							want.evicted_page, evicted_page);
						mismatches++;
					end
					if (fault_total !== want.fault_total) begin
						$error("fault_total: expected %0d, got %0d",
							want.fault_total, fault_total);
						mismatches++;
					end
				end
			end
		end
		page_taken <= page_valid && !page_stall;
		silent_cycles <= activity ? 0 : silent_cycles + 1;
	end

	initial begin
		wait (silent_cycles >= SILENT_MAX);
		$display("lru_page_replacement verification failed");
		$finish;
	end

	initial begin : stimulus_plan
		logic [PAGE_W-1:0] working[$];
		logic [CFG_W-1:0]  setting;
		int                active;
		int                pick;
		int                roll;

		add_page(16'h0000);
		add_page(16'hFFFF);
		add_page(16'h0001);
		add_page(16'h8000);
		add_page(16'h0000);
		add_page(16'hFFFF);
		add_page(16'hAAAA);
		add_page(16'h5555);
		add_page(16'hAAAA);
		add_frames(4'd15);
		add_page(16'h1111);
		add_page(16'h2222);
		add_page(16'h3333);
		add_page(16'h4444);
		add_page(16'h0000);
		add_frames(4'd2);
		add_page(16'h3333);
		add_page(16'h3333);
		add_frames(4'd0);
		add_page(16'h7FFF);
		add_page(16'h7FFF);
		add_frames(4'd8);
		add_page(16'h4444);
		add_page(16'h2222);
		add_page(16'hFFFE);
		add_quiesce();
		add_frames(4'd1);
		add_page(16'h0F0F);

		for (int c = 0; c < CHUNKS; c++) begin
			case (c % 4)
				0: add_pacing(0, 0);
				1: add_pacing(63, 0);
				2: add_pacing(0, 63);
				default: add_pacing(34, 34);
			endcase
			case (c)
				0: setting = 4'd8;
				1: setting = 4'd1;
				2: setting = 4'd15;
				3: setting = 4'd0;
				default: setting = 4'($urandom_range(15));
			endcase
			add_frames(setting);
			active = (setting == 0) ? 1 : ((setting > NUM_FRAMES) ? NUM_FRAMES :
				int'(setting));
			working.delete();
			for (int i = 0; i < active + int'($urandom_range(3)); i++)
				working.push_back(PAGE_W'($urandom));
			for (int n = 0; n < CHUNK_ITEMS; n++) begin
				roll = $urandom_range(99);
				pick = $urandom_range(working.size() - 1);
				if (roll < 85) begin
					add_page(working[pick]);
				end else if (roll < 95) begin
					add_page(PAGE_W'($urandom));
				end else begin
					working[pick] = PAGE_W'($urandom);
					add_page(working[pick]);
				end
				if (n == CHUNK_ITEMS / 2 && c % 3 == 1)
					add_quiesce();
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stimulus.size() != 0 || page_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("lru_page_replacement verification clean");
		else
			$display("lru_page_replacement verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/lru_pkg.sv
hdl/lru_cell.sv
hdl/lru_pick.sv
hdl/lru_page_replacement.sv
sim/lru_page_replacement_tb.sv
